### rtl/core/dcpe_pkg.sv
// Shared constants and types for the Dirichlet count probability estimator.
// Used by the top level and the testbench; depends on nothing.
package dcpe_pkg;

  // Table geometry and fixed point formats
  localparam int MAX_CATEGORIES  = 256;
  localparam int COUNT_FRAC_BITS = 8;
  localparam int PROB_BITS       = 16;

  localparam int ADDR_W  = $clog2(MAX_CATEGORIES);
  localparam int CAT_W   = 8;
  localparam int NCAT_W  = 9;
  localparam int PRIOR_W = 16;
  localparam int CNT_W   = 32;
  localparam int TOT_W   = 40;
  localparam int PROB_W  = PROB_BITS + 1;
  localparam int STEP_W  = $clog2(PROB_BITS);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int PRIOR_SHL = (COUNT_FRAC_BITS >= 8) ? COUNT_FRAC_BITS - 8 : 0;
  localparam int PRIOR_SHR = (COUNT_FRAC_BITS >= 8) ? 0 : 8 - COUNT_FRAC_BITS;

  localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1) << COUNT_FRAC_BITS;
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [TOT_W-1:0]  TOT_MAX  = {TOT_W{1'b1}};
  localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_BITS;

  // Reset values of the configuration registers
  localparam logic [NCAT_W-1:0]  NUM_CAT_RESET = NCAT_W'(2);
  localparam logic [PRIOR_W-1:0] PRIOR_RESET   = PRIOR_W'(256);

  // Operation codes
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_OBSERVE = 2'd1,
    OP_ADD     = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CATEGORIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIOR_COUNT    = 1'b1;

  // Sequencer states
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_READ   = 9'b000000010,
    ST_LOAD   = 9'b000000100,
    ST_CMP    = 9'b000001000,
    ST_DIV    = 9'b000010000,
    ST_ADD    = 9'b000100000,
    ST_LAST   = 9'b001000000,
    ST_CLEAR  = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_t;

  // Bring the UQ8.8 prior into the count format
  function automatic logic [CNT_W-1:0] prior_scaled(input logic [PRIOR_W-1:0] pr);
    return (CNT_W'(pr) << PRIOR_SHL) >> PRIOR_SHR;
  endfunction

endpackage

### rtl/core/dirichlet_count_probability_estimator.sv
// Dirichlet pseudo-count probability estimator: counts table, total, observation count.
// Depends on dcpe_pkg and dcpe_ram.
// A query reads the entry, compares it with the total and runs the radix-2 divider, one
// quotient bit per cycle, skipped when the count reaches the total; observe then updates
// the count. Add updates it and with last closes the batch; clear sweeps the used entries.
// Throughput: one transaction at a time; the next is accepted the cycle after the result is
// loaded into the output register. Reset: synchronous; entries read as 1.0 through per-entry
// valid bits, total is 2.0.
module dirichlet_count_probability_estimator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       op,
  input  logic [dcpe_pkg::CAT_W-1:0]       category,
  input  logic [dcpe_pkg::CNT_W-1:0]       amount,
  input  logic                             last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dcpe_pkg::PROB_W-1:0]      probability,
  output logic [dcpe_pkg::CNT_W-1:0]       observations,
  output logic                             saturated,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dcpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dcpe_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dcpe_pkg::*;

  state_t state;

  logic [NCAT_W-1:0]  num_cat;
  logic [PRIOR_W-1:0] prior;
  logic [NCAT_W-1:0]  n_used;
  logic [CNT_W-1:0]   prior_p;
  logic [NCAT_W+CNT_W-1:0] clr_prod;

  op_t               op_q;
  logic [CAT_W-1:0]  cat_q;
  logic [CNT_W-1:0]  amount_q;
  logic              last_q;

  logic [TOT_W-1:0]  total;
  logic [CNT_W-1:0]  observed;
  logic [TOT_W-1:0]  batch_sum;
  logic [CNT_W-1:0]  cnt;
  logic [TOT_W-1:0]  rem;
  logic [TOT_W-1:0]  den;
  logic [PROB_W-1:0] prob;
  logic [STEP_W-1:0] step;
  logic [NCAT_W-1:0] idx;
  logic              sat;

  logic [MAX_CATEGORIES-1:0] valid;
  logic                      vld_q;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CNT_W-1:0]   ram_wdata;
  logic [CNT_W-1:0]   ram_rdata;

  logic               accept;
  logic               in_use;
  logic [CNT_W-1:0]   count_val;
  logic [TOT_W:0]     rem2;
  logic               q_bit;
  logic [CNT_W-1:0]   addend;
  logic [CNT_W:0]     cnt_sum;
  logic [TOT_W:0]     tot_sum;
  logic [TOT_W:0]     batch_add;
  logic [CNT_W:0]     obs_inc;
  logic [CNT_W:0]     obs_batch;
  logic               out_free;

  // Effective category count: zero acts as one, clamp to table depth
  always_comb begin
    if (num_cat == '0) begin
      n_used = NCAT_W'(1);
    end else if (num_cat > NCAT_W'(MAX_CATEGORIES)) begin
      n_used = NCAT_W'(MAX_CATEGORIES);
    end else begin
      n_used = num_cat;
    end
  end

  assign prior_p  = prior_scaled(prior);
  assign clr_prod = n_used * prior_p;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign in_use    = ({1'b0, category} < n_used);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  // Datapath arithmetic
  assign count_val = vld_q ? ram_rdata : CNT_ONE;
  assign rem2      = {rem, 1'b0};
  assign q_bit     = (rem2 >= {1'b0, den});
  assign addend    = (op_q == OP_OBSERVE) ? CNT_ONE : amount_q;
  assign cnt_sum   = {1'b0, cnt} + {1'b0, addend};
  assign tot_sum   = {1'b0, total} + (TOT_W + 1)'(addend);
  assign batch_add = {1'b0, batch_sum} + (TOT_W + 1)'(amount_q);
  assign obs_inc   = {1'b0, observed} + (CNT_W + 1)'(1);
  assign obs_batch = {1'b0, observed}
                   + (CNT_W + 1)'(batch_sum[TOT_W-1:COUNT_FRAC_BITS]);

  // Counts table write port: clear sweep or count update
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cat_q;
    ram_wdata = cnt_sum[CNT_W] ? CNT_MAX : cnt_sum[CNT_W-1:0];
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = idx[ADDR_W-1:0];
      ram_wdata = prior_p;
    end else if (state == ST_ADD) begin
      ram_we    = 1'b1;
    end
  end

  dcpe_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_CATEGORIES)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cat_q),
    .rdata (ram_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cat <= NUM_CAT_RESET;
      prior   <= PRIOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_CATEGORIES: num_cat <= cfg_data[NCAT_W-1:0];
        REG_PRIOR_COUNT:    prior   <= cfg_data[PRIOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Entry valid bits: an entry never written reads as 1.0
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (state == ST_CLEAR) begin
      valid[idx[ADDR_W-1:0]] <= 1'b1;
    end else if (state == ST_ADD) begin
      valid[cat_q] <= 1'b1;
    end
  end

  // Track the valid bit alongside the registered RAM read
  always_ff @(posedge clk) begin
    vld_q <= valid[cat_q];
  end

  // Raise the result valid at hand-over, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer and estimator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      total     <= TOT_W'(2) << COUNT_FRAC_BITS;
      observed  <= '0;
      batch_sum <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_q     <= op_t'(op);
            cat_q    <= category;
            amount_q <= amount;
            last_q   <= last;
            prob     <= '0;
            sat      <= 1'b0;
            idx      <= '0;
            unique case (op_t'(op))
              OP_CLEAR: begin
                total     <= TOT_W'(clr_prod);
                batch_sum <= '0;
                state     <= ST_CLEAR;
              end
              OP_ADD: begin
                if (in_use) begin
                  state <= ST_READ;
                end else if (last) begin
                  state <= ST_LAST;
                end else begin
                  state <= ST_FINISH;
                end
              end
              default: begin
                state <= in_use ? ST_READ : ST_FINISH;
              end
            endcase
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          cnt <= count_val;
          if (op_q == OP_ADD) begin
            state <= ST_ADD;
          end else begin
            // Zero total falls back to one over the category count
            if (total == '0) begin
              rem <= TOT_W'(1);
              den <= TOT_W'(n_used);
            end else begin
              rem <= TOT_W'(count_val);
              den <= total;
            end
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          step <= '0;
          if (rem >= den) begin
            prob  <= PROB_ONE;
            state <= (op_q == OP_OBSERVE) ? ST_ADD : ST_FINISH;
          end else begin
            prob  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle
          rem  <= q_bit ? TOT_W'(rem2 - {1'b0, den}) : rem2[TOT_W-1:0];
          prob <= {prob[PROB_W-2:0], q_bit};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(PROB_BITS - 1)) begin
            state <= (op_q == OP_OBSERVE) ? ST_ADD : ST_FINISH;
          end
        end
        ST_ADD: begin
          total <= tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
          if (op_q == OP_OBSERVE) begin
            observed <= obs_inc[CNT_W] ? CNT_MAX : obs_inc[CNT_W-1:0];
            sat      <= sat | cnt_sum[CNT_W] | tot_sum[TOT_W] | obs_inc[CNT_W];
            state    <= ST_FINISH;
          end else begin
            batch_sum <= batch_add[TOT_W] ? TOT_MAX : batch_add[TOT_W-1:0];
            sat       <= sat | cnt_sum[CNT_W] | tot_sum[TOT_W] | batch_add[TOT_W];
            state     <= last_q ? ST_LAST : ST_FINISH;
          end
        end
        ST_LAST: begin
          // Close the batch into the observation count
          observed  <= obs_batch[CNT_W] ? CNT_MAX : obs_batch[CNT_W-1:0];
          sat       <= sat | obs_batch[CNT_W];
          batch_sum <= '0;
          state     <= ST_FINISH;
        end
        ST_CLEAR: begin
          idx <= idx + NCAT_W'(1);
          if (idx == n_used - NCAT_W'(1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Hand the result to the output register when it is free
          if (out_free) begin
            probability  <= prob;
            observations <= observed;
            saturated    <= sat;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // An accepted transaction always leaves the idle state
  assert property (@(posedge clk) disable iff (rst) accept |=> in_stall)
    else $error("accepted transaction did not start the sequencer");

  // Partial remainder stays below the divisor through the divider loop
  assert property (@(posedge clk) disable iff (rst) (state == ST_DIV) |-> (rem < den))
    else $error("divider remainder not below divisor");

  // Divider exits only to the count update or the result
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |=> (state == ST_DIV || state == ST_ADD || state == ST_FINISH))
    else $error("divider left to an unexpected state");

  // Clear sweep stays inside the categories in use
  assert property (@(posedge clk) disable iff (rst) (state == ST_CLEAR) |-> (idx < n_used))
    else $error("clear sweep beyond categories in use");

  // A probability never exceeds one
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (probability <= PROB_ONE))
    else $error("probability above one");

endmodule

### rtl/core/dcpe_ram.sv
// Generic single write port RAM with one registered read port.
// Holds the per-category pseudo-counts; no package dependency.
module dcpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sim/tb_top.sv
// Testbench for the Dirichlet count probability estimator: a directed table, random phases, then a sweep.
// Every result is checked against an in-bench predictor of the counts table and totals, or a typed-in expectation.
// Depends on dcpe_pkg and dirichlet_count_probability_estimator.
module tb_top;
  import dcpe_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_CAP   = 40;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 55;
  localparam int SWEEP_ITEMS  = 300;

  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic [CNT_W-1:0]  obs;
    logic              sat;
  } estimate_t;

  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  widx;
    logic [CFG_DATA_W-1:0] wdata;
    op_t                   opc;
    logic [CAT_W-1:0]      cat;
    logic [CNT_W-1:0]      amt;
    logic                  lst;
    bit                    typed;
    estimate_t             want;
  } plan_row_t;

  // DUT connections, all driven to known values from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            op = OP_QUERY;
  logic [CAT_W-1:0]      category = '0;
  logic [CNT_W-1:0]      amount = '0;
  logic                  last = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PROB_W-1:0]     probability;
  logic [CNT_W-1:0]      observations;
  logic                  saturated;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Side band that travels with a transaction: a typed-in expectation
  bit        row_typed = 1'b0;
  estimate_t row_want = '0;

  // Predictor state and its copy of the registers
  logic [CNT_W-1:0]   pseudo_counts [MAX_CATEGORIES];
  logic [TOT_W-1:0]   count_total;
  logic [CNT_W-1:0]   obs_count;
  logic [TOT_W-1:0]   batch_weight;
  logic [NCAT_W-1:0]  ncat_reg;
  logic [PRIOR_W-1:0] prior_reg;

  estimate_t pending_estimates [$];
  plan_row_t directed_plan [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        stall_mode = 1;
  bit        bursty = 1'b1;
  int        burst_left = 4;

  dirichlet_count_probability_estimator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .category(category), .amount(amount), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .probability(probability), .observations(observations), .saturated(saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] clamp_add(logic [63:0] a, logic [63:0] b, logic [63:0] lim,
                                            inout bit hit);
    logic [63:0] s;
    s = a + b;
    if (s > lim) begin
      hit = 1'b1;
      return lim;
    end
    return s;
  endfunction

  function automatic int active_categories();
    if (ncat_reg == 0) return 1;
    if (int'(ncat_reg) > MAX_CATEGORIES) return MAX_CATEGORIES;
    return int'(ncat_reg);
  endfunction

  // Count over total in UQ1.16, capped at one; even split when the total is zero
  function automatic logic [PROB_W-1:0] share_of(logic [CAT_W-1:0] idx);
    logic [63:0] one;
    logic [63:0] q;
    one = 64'd1 << PROB_BITS;
    if (count_total == 0) return PROB_W'(one / 64'(active_categories()));
    q = (64'(pseudo_counts[idx]) << PROB_BITS) / 64'(count_total);
    return (q > one) ? PROB_W'(one) : PROB_W'(q);
  endfunction

  // Apply one transaction to the table and return the result it should produce
  function automatic estimate_t step_estimator(op_t o, logic [CAT_W-1:0] c,
                                               logic [CNT_W-1:0] a, logic l);
    int          n;
    bit          in_use;
    bit          hit;
    logic [63:0] p;
    estimate_t   r;
    n = active_categories();
    in_use = int'(c) < n;
    hit = 1'b0;
    r = '0;
    case (o)
      OP_CLEAR: begin
        p = (64'(prior_reg) << PRIOR_SHL) >> PRIOR_SHR;
        for (int i = 0; i < n; i++) pseudo_counts[i] = CNT_W'(p);
        count_total = TOT_W'(64'(n) * p);
        batch_weight = '0;
      end
      OP_OBSERVE: begin
        if (in_use) begin
          r.prob = share_of(c);
          pseudo_counts[c] = CNT_W'(clamp_add(pseudo_counts[c], CNT_ONE, CNT_MAX, hit));
          count_total = TOT_W'(clamp_add(count_total, CNT_ONE, TOT_MAX, hit));
          obs_count = CNT_W'(clamp_add(obs_count, 64'd1, CNT_MAX, hit));
        end
      end
      OP_ADD: begin
        if (in_use) begin
          pseudo_counts[c] = CNT_W'(clamp_add(pseudo_counts[c], a, CNT_MAX, hit));
          count_total = TOT_W'(clamp_add(count_total, a, TOT_MAX, hit));
          batch_weight = TOT_W'(clamp_add(batch_weight, a, TOT_MAX, hit));
        end
        if (l) begin
          obs_count = CNT_W'(clamp_add(obs_count, batch_weight >> COUNT_FRAC_BITS,
                                       CNT_MAX, hit));
          batch_weight = '0;
        end
      end
      default: begin
        if (in_use) r.prob = share_of(c);
      end
    endcase
    r.obs = obs_count;
    r.sat = hit;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP)
      $display("mismatch: %s got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
  endtask

  // Check results, then track register writes and accepted transactions
  always @(posedge clk) begin : track_block
    estimate_t want;
    estimate_t predicted;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_estimates.size() == 0) begin
          report_mismatch("result with nothing pending", probability, 0);
        end else begin
          want = pending_estimates.pop_front();
          if (probability !== want.prob) report_mismatch("probability", probability, want.prob);
          if (observations !== want.obs) report_mismatch("observations", observations, want.obs);
          if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM_CATEGORIES: ncat_reg = cfg_data[NCAT_W-1:0];
          REG_PRIOR_COUNT:    prior_reg = cfg_data[PRIOR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predicted = step_estimator(op_t'(op), category, amount, last);
        pending_estimates.push_back(row_typed ? row_want : predicted);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- receiver

  // Stall the result side in runs of random length; mode 0 never stalls
  int stall_run = 0;
  always @(negedge clk) begin
    if (rst || stall_mode == 0) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      out_stall <= !out_stall;
      stall_run = out_stall ? $urandom_range(0, 8)
                            : $urandom_range(0, (stall_mode == 2) ? 12 : 3);
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_item(op_t o, logic [CAT_W-1:0] c, logic [CNT_W-1:0] a, logic l,
                           bit t, estimate_t w);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    op <= o;
    category <= c;
    amount <= a;
    last <= l;
    row_typed <= t;
    row_want <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // end the burst with a random gap
    if (bursty) begin
      burst_left--;
      if (burst_left <= 0) begin
        gap = $urandom_range(1, 8);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void put_item(op_t o, logic [CAT_W-1:0] c, logic [CNT_W-1:0] a,
                                   logic l);
    plan_row_t r;
    r = '{opc: OP_CLEAR, default: '0};
    r.opc = o;
    r.cat = c;
    r.amt = a;
    r.lst = l;
    directed_plan.push_back(r);
  endfunction

  function automatic void put_typed(op_t o, logic [CAT_W-1:0] c, logic [CNT_W-1:0] a,
                                    logic l, logic [PROB_W-1:0] p, logic [CNT_W-1:0] obs,
                                    logic s);
    plan_row_t r;
    r = '{opc: OP_CLEAR, default: '0};
    r.opc = o;
    r.cat = c;
    r.amt = a;
    r.lst = l;
    r.typed = 1'b1;
    r.want = '{prob: p, obs: obs, sat: s};
    directed_plan.push_back(r);
  endfunction

  function automatic void put_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r = '{opc: OP_CLEAR, default: '0};
    r.is_write = 1'b1;
    r.widx = idx;
    r.wdata = data;
    directed_plan.push_back(r);
  endfunction

  // ---------------------------------------------------------------- stimulus

  initial begin
    plan_row_t          row;
    op_t                o;
    logic [NCAT_W-1:0]  ncat_sel;
    logic [PRIOR_W-1:0] prior_sel;
    logic [CNT_W-1:0]   a;
    int                 n_eff;
    int                 c;
    int                 roll;

    // Predictor after reset: every entry 1.0, total 2.0
    for (int i = 0; i < MAX_CATEGORIES; i++) pseudo_counts[i] = CNT_ONE;
    count_total = TOT_W'(2) << COUNT_FRAC_BITS;
    obs_count = '0;
    batch_weight = '0;
    ncat_reg = NUM_CAT_RESET;
    prior_reg = PRIOR_RESET;

    // Reset state, saturation on a count, out-of-use categories
    put_typed(OP_QUERY, 8'd0, 32'd0, 1'b0, 17'd32768, 32'd0, 1'b0);
    put_typed(OP_QUERY, 8'd255, 32'hFFFF_FFFF, 1'b1, 17'd0, 32'd0, 1'b0);
    put_typed(OP_OBSERVE, 8'd0, 32'd0, 1'b0, 17'd32768, 32'd1, 1'b0);
    put_item(OP_OBSERVE, 8'd1, 32'h5A5A_5A5A, 1'b1);
    put_typed(OP_ADD, 8'd0, 32'hFFFF_FFFF, 1'b0, 17'd0, 32'd2, 1'b1);
    put_item(OP_ADD, 8'd1, 32'h0000_0100, 1'b1);
    put_item(OP_QUERY, 8'd0, 32'd0, 1'b0);
    put_item(OP_ADD, 8'd200, 32'd5, 1'b1);
    put_item(OP_ADD, 8'd1, 32'd0, 1'b0);
    put_item(OP_QUERY, 8'd1, 32'd0, 1'b0);
    // One category with a half prior, upper data bits ignored; then widen without a clear
    put_write(REG_NUM_CATEGORIES, 16'hAE01);
    put_write(REG_PRIOR_COUNT, 16'h0080);
    put_item(OP_CLEAR, 8'd7, 32'd0, 1'b0);
    put_write(REG_NUM_CATEGORIES, 16'h0100);
    put_item(OP_QUERY, 8'd1, 32'd0, 1'b0);
    put_item(OP_QUERY, 8'd255, 32'd0, 1'b0);
    // Zero prior gives a zero total
    put_write(REG_PRIOR_COUNT, 16'h0000);
    put_item(OP_CLEAR, 8'd0, 32'd0, 1'b0);
    put_item(OP_QUERY, 8'd3, 32'd0, 1'b0);
    put_item(OP_OBSERVE, 8'd255, 32'd0, 1'b0);
    // Zero categories acts as one; largest prior
    put_write(REG_NUM_CATEGORIES, 16'h0000);
    put_write(REG_PRIOR_COUNT, 16'hFFFF);
    put_item(OP_QUERY, 8'd0, 32'd0, 1'b0);
    put_item(OP_QUERY, 8'd1, 32'd0, 1'b0);
    put_item(OP_CLEAR, 8'd0, 32'd0, 1'b0);
    put_item(OP_OBSERVE, 8'd0, 32'd0, 1'b0);
    // Above the table depth acts as the full table
    put_write(REG_NUM_CATEGORIES, 16'h01FF);
    put_item(OP_QUERY, 8'd255, 32'd0, 1'b0);
    put_item(OP_ADD, 8'd255, 32'hFFFF_FFFF, 1'b0);
    put_item(OP_ADD, 8'd254, 32'hFFFF_FFFF, 1'b0);
    put_item(OP_ADD, 8'd128, 32'h8000_0001, 1'b1);
    put_item(OP_QUERY, 8'd0, 32'd0, 1'b0);
    put_item(OP_CLEAR, 8'd0, 32'd0, 1'b0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.is_write) begin
        wait_idle();
        write_reg(row.widx, row.wdata);
      end else begin
        send_item(row.opc, row.cat, row.amt, row.lst, row.typed, row.want);
      end
    end

    // Random phases, each under a fresh setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0: ncat_sel = NCAT_W'($urandom_range(0, 8));
        1: ncat_sel = NCAT_W'($urandom_range(2, 64));
        2: ncat_sel = NCAT_W'(MAX_CATEGORIES);
        3: ncat_sel = NCAT_W'($urandom_range(257, 511));
        default: ncat_sel = NCAT_W'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 4))
        0: prior_sel = '0;
        1: prior_sel = '1;
        2: prior_sel = PRIOR_W'($urandom);
        3: prior_sel = PRIOR_RESET;
        default: prior_sel = PRIOR_W'($urandom_range(1, 1024));
      endcase
      n_eff = (ncat_sel == 0) ? 1 : (int'(ncat_sel) > MAX_CATEGORIES) ? MAX_CATEGORIES
                                                                       : int'(ncat_sel);
      wait_idle();
      if ($urandom_range(0, 1)) begin
        write_reg(REG_NUM_CATEGORIES, {7'($urandom), ncat_sel});
        write_reg(REG_PRIOR_COUNT, prior_sel);
      end else begin
        write_reg(REG_PRIOR_COUNT, prior_sel);
        write_reg(REG_NUM_CATEGORIES, {7'($urandom), ncat_sel});
      end
      stall_mode = ph % 3;
      bursty = (ph % 4) != 0;
      if ($urandom_range(0, 1))
        send_item(OP_CLEAR, CAT_W'($urandom), $urandom, 1'($urandom), 1'b0, '0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        c = ($urandom_range(0, 9) < 8) ? $urandom_range(0, n_eff - 1) : $urandom_range(0, 255);
        roll = $urandom_range(0, 99);
        if (roll < 8) o = OP_CLEAR;
        else if (roll < 35) o = OP_OBSERVE;
        else if (roll < 75) o = OP_ADD;
        else o = OP_QUERY;
        case ($urandom_range(0, 7))
          0:       a = '0;
          1, 2, 3: a = $urandom_range(1, 4095);
          4, 5:    a = $urandom;
          6:       a = $urandom_range(0, 20'hFFFFF);
          default: a = '1;
        endcase
        send_item(o, CAT_W'(c), a, $urandom_range(0, 3) == 0, 1'b0, '0);
      end
    end

    // Saturation sweep: heavy weights over the full table in two long batches
    wait_idle();
    write_reg(REG_NUM_CATEGORIES, NCAT_W'(MAX_CATEGORIES));
    write_reg(REG_PRIOR_COUNT, PRIOR_W'($urandom));
    stall_mode = 2;
    bursty = 1'b1;
    send_item(OP_CLEAR, 8'd0, 32'd0, 1'b0, 1'b0, '0);
    for (int k = 0; k < SWEEP_ITEMS; k++) begin
      if (k % 8 == 7) begin
        o = $urandom_range(0, 1) ? OP_OBSERVE : OP_QUERY;
        send_item(o, CAT_W'($urandom), $urandom, 1'b0, 1'b0, '0);
      end else begin
        a = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 255) : '1;
        send_item(OP_ADD, CAT_W'($urandom), a, k == 270 || k == SWEEP_ITEMS - 1, 1'b0, '0);
      end
    end

    // Drain and settle
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
